### rtl/mbt_pkg.sv
// mbt_pkg: types and constants shared by the multiset bag table.
// No dependencies; imported by every other module of the block except mbt_ram.
`timescale 1ns / 1ps

package mbt_pkg;

   localparam int VALUE_W = 32;
   localparam int FIELD_CNT_W = 6;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE_ALL = 2'd1,
      OP_ERASE_ONE = 2'd2,
      OP_COUNT = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [FIELD_CNT_W-1:0] match_count;
      logic found;
      logic full_error;
      logic [FIELD_CNT_W-1:0] bag_size;
   } rsp_type;

   typedef struct packed {
      op_type op;
      logic [VALUE_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic valid;
      cmd_type cmd;
   } cmd_q_type;

endpackage

### rtl/mbt_ram.sv
// mbt_ram: generic single-write, single-read RAM with registered read data.
// No package dependency; used by mbt_back for the entry store.
`timescale 1ns / 1ps

module mbt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mbt_front.sv
// mbt_front: accepts request words, decodes the opcode and queues commands.
// Depends on mbt_pkg; feeds mbt_back through a two-word queue.
`timescale 1ns / 1ps

module mbt_front
   import mbt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  req_type   req_word,
   input  logic      cmd_pop,
   output cmd_q_type cmd_q
);

   cmd_type    q_ff [2];
   logic [1:0] q_cnt_ff, q_cnt_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push;
   logic       pop;
   cmd_type    cmd_dec;

   always_comb begin
      cmd_dec.value = unsigned'(req_word.value);
      case (req_word.opcode)
         OP_INSERT: cmd_dec.op = OP_INSERT;
         OP_ERASE_ALL: cmd_dec.op = OP_ERASE_ALL;
         OP_ERASE_ONE: cmd_dec.op = OP_ERASE_ONE;
         default: cmd_dec.op = OP_COUNT;
      endcase
   end

   assign busy = (q_cnt_ff == 2'd2);
   assign push = start && !busy;
   assign pop = cmd_pop && (q_cnt_ff != 2'd0);

   always_comb begin
      q_cnt_in = q_cnt_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         q_cnt_in = q_cnt_ff + 2'd1;
      end else if (pop && !push) begin
         q_cnt_in = q_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_dec;
      end
   end

   assign cmd_q.valid = (q_cnt_ff != 2'd0);
   assign cmd_q.cmd = q_ff[rd_ptr_ff];

endmodule

### rtl/mbt_back.sv
// mbt_back: executes queued commands against the entry store, one at a time.
// Depends on mbt_pkg and mbt_ram; results leave through a one-cycle strobe.
`timescale 1ns / 1ps

module mbt_back
   import mbt_pkg::*;
#(
   parameter int BAG_CAPACITY = 32,
   localparam int CNT_W = $clog2(BAG_CAPACITY + 1),
   localparam int ADDR_W = (BAG_CAPACITY > 1) ? $clog2(BAG_CAPACITY) : 1
) (
   input  logic      clock,
   input  logic      reset,
   input  cmd_q_type cmd_q,
   output logic      cmd_pop,
   output logic      rsp_strobe,
   output rsp_type   rsp_word
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_CMP  = 4'b0100,
      S_MOVE = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   match_ff, match_in;
   op_type             op_ff, op_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [VALUE_W-1:0] rd_data;

   logic               hit;
   logic [CNT_W-1:0]   idx_nxt;
   logic [CNT_W-1:0]   cnt_dec;

   assign hit = (rd_data == value_ff);
   assign idx_nxt = idx_ff + CNT_W'(1);
   assign cnt_dec = cnt_ff - CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      match_in = match_ff;
      op_in = op_ff;
      value_in = value_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      cmd_pop = 1'b0;
      wr_en = 1'b0;
      wr_addr = idx_ff[ADDR_W-1:0];
      wr_data = rd_data;
      rd_en = 1'b0;
      rd_addr = idx_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (cmd_q.valid) begin
               cmd_pop = 1'b1;
               op_in = cmd_q.cmd.op;
               value_in = cmd_q.cmd.value;
               idx_in = '0;
               match_in = '0;
               rsp_in = '0;
               if (cmd_q.cmd.op == OP_INSERT) begin
                  rsp_valid_in = 1'b1;
                  if (cnt_ff < CNT_W'(BAG_CAPACITY)) begin
                     wr_en = 1'b1;
                     wr_addr = cnt_ff[ADDR_W-1:0];
                     wr_data = cmd_q.cmd.value;
                     cnt_in = cnt_ff + CNT_W'(1);
                     rsp_in.found = 1'b1;
                  end else begin
                     rsp_in.full_error = 1'b1;
                  end
                  rsp_in.bag_size = FIELD_CNT_W'(cnt_in);
               end else if (cnt_ff == '0) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = '0;
                  state_in = S_CMP;
               end
            end
         end
         S_READ: begin
            rd_en = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (hit && op_ff != OP_COUNT) begin
               cnt_in = cnt_dec;
               match_in = match_ff + CNT_W'(1);
               if (idx_ff == cnt_dec) begin
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = cnt_dec[ADDR_W-1:0];
                  state_in = S_MOVE;
               end
            end else begin
               if (hit) begin
                  match_in = match_ff + CNT_W'(1);
               end
               if (idx_nxt == cnt_ff) begin
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_nxt;
                  rd_en = 1'b1;
                  rd_addr = idx_nxt[ADDR_W-1:0];
               end
            end
         end
         S_MOVE: begin
            wr_en = 1'b1;
            if (op_ff == OP_ERASE_ONE) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_valid_in && op_ff != OP_INSERT && state_ff != S_IDLE) begin
         rsp_in.found = (op_ff == OP_ERASE_ONE) && (match_in != '0);
         rsp_in.full_error = 1'b0;
         rsp_in.match_count = (op_ff == OP_ERASE_ONE) ? '0 : FIELD_CNT_W'(match_in);
         rsp_in.bag_size = FIELD_CNT_W'(cnt_in);
      end else if (rsp_valid_in && state_ff == S_IDLE && cmd_q.cmd.op != OP_INSERT) begin
         rsp_in.bag_size = FIELD_CNT_W'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      match_ff <= match_in;
      op_ff <= op_in;
      value_ff <= value_in;
      rsp_ff <= rsp_in;
   end

   mbt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (BAG_CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word = rsp_ff;

endmodule

### rtl/multiset_bag_table.sv
// multiset_bag_table: top level of the fixed-capacity multiset bag.
// Depends on mbt_pkg, mbt_front, mbt_back (which holds mbt_ram).
`timescale 1ns / 1ps

// A request word is taken when start is high and busy is low; a two-word
// command queue sits in front of the execution engine, so busy rises only
// when two commands are waiting. Each request gives exactly one result word,
// shown on rsp_word for one cycle with rsp_strobe high; the receiver cannot
// stall it. Insert and any command on an empty bag answer from the idle state
// without a RAM read. Count, erase-one and erase-all scan the stored entries
// at one entry per cycle through the entry RAM's single registered read port;
// every entry removed by erase-all from below the last slot adds a move of
// the last entry into the hole (S_MOVE) and a reread of the slot (S_READ).
// Erase-one stops at its match and then moves the last entry into the hole
// unless the match was the last entry. The store needs no clearing after
// reset.
module multiset_bag_table
   import mbt_pkg::*;
#(
   parameter int BAG_CAPACITY = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   cmd_q_type cmd_q;
   logic      cmd_pop;

   mbt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .cmd_pop  (cmd_pop),
      .cmd_q    (cmd_q)
   );

   mbt_back #(
      .BAG_CAPACITY (BAG_CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_q      (cmd_q),
      .cmd_pop    (cmd_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   a_found_full_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_word.found && rsp_word.full_error))
      else $error("found and full_error both set");

   a_full_at_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.full_error) |->
         (rsp_word.bag_size == FIELD_CNT_W'(BAG_CAPACITY)))
      else $error("full_error below capacity");

   a_count_no_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.match_count != '0) |-> !rsp_word.found)
      else $error("match_count with found");

endmodule

### sim/tb.sv
// tb: self-checking bench for multiset_bag_table, driving command words and
// checking each result word against an internal bag predictor.
// Depends on mbt_pkg and the multiset_bag_table RTL.
`timescale 1ns / 1ps

module tb;
   import mbt_pkg::*;

   localparam int BAG_CAPACITY = 32;
   localparam int RANDOM_ITEMS = 1000;
   localparam int BLOCK_ITEMS  = 50;
   localparam int QUIET_TAIL   = 150;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 150;
   localparam int REPORT_MAX   = 10;

   class bag_scoreboard;
      logic [VALUE_W-1:0] held_vals[BAG_CAPACITY];
      int unsigned held_count;
      rsp_type pending_rsp[$];
      int unsigned mismatch_count;

      function new();
         held_count = 0;
         mismatch_count = 0;
      endfunction

      function void note_request(req_type r);
         rsp_type exp;
         int unsigned i;
         int unsigned hit_total;
         logic [VALUE_W-1:0] key;
         key = r.value;
         hit_total = 0;
         exp = '0;
         case (op_type'(r.opcode))
            OP_INSERT: begin
               if (held_count < BAG_CAPACITY) begin
                  held_vals[held_count] = key;
                  held_count++;
                  exp.found = 1'b1;
               end else begin
                  exp.full_error = 1'b1;
               end
            end
            OP_ERASE_ALL: begin
               i = 0;
               // moved-in last entry lands in slot i and is rechecked
               while (i < held_count) begin
                  if (held_vals[i] == key) begin
                     held_count--;
                     held_vals[i] = held_vals[held_count];
                     hit_total++;
                  end else begin
                     i++;
                  end
               end
            end
            OP_ERASE_ONE: begin
               for (i = 0; i < held_count; i++) begin
                  if (held_vals[i] == key) begin
                     held_count--;
                     held_vals[i] = held_vals[held_count];
                     exp.found = 1'b1;
                     break;
                  end
               end
            end
            default: begin
               for (i = 0; i < held_count; i++)
                  if (held_vals[i] == key) hit_total++;
            end
         endcase
         exp.match_count = hit_total[FIELD_CNT_W-1:0];
         exp.bag_size = held_count[FIELD_CNT_W-1:0];
         pending_rsp.push_back(exp);
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("mbt mismatch: unexpected result cnt=%0d fnd=%0d full=%0d size=%0d",
                        got.match_count, got.found, got.full_error, got.bag_size);
            return;
         end
         exp = pending_rsp.pop_front();
         if (got.match_count !== exp.match_count || got.found !== exp.found ||
             got.full_error !== exp.full_error || got.bag_size !== exp.bag_size) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display({"mbt mismatch @%0t: exp cnt=%0d fnd=%0d full=%0d size=%0d,",
                         " got cnt=%0d fnd=%0d full=%0d size=%0d"},
                        $realtime, exp.match_count, exp.found, exp.full_error, exp.bag_size,
                        got.match_count, got.found, got.full_error, got.bag_size);
         end
      endfunction

      function bit drained();
         return pending_rsp.size() == 0;
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_strobe;
   rsp_type rsp_word;

   bag_scoreboard sb;
   logic [VALUE_W-1:0] value_pool[8];
   int unsigned stall_cycles;

   multiset_bag_table #(.BAG_CAPACITY(BAG_CAPACITY)) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial sb = new();

   always @(posedge clock) begin
      if (!reset && start && !busy) sb.note_request(req_word);
      if (!reset && rsp_strobe) sb.check_response(rsp_word);
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("[multiset_bag_table] ERROR");
      $finish;
   end

   // call only at a rising edge; returns at the edge that takes the word
   task automatic send_word(input op_type op, input logic [VALUE_W-1:0] val);
      req_type r;
      r.opcode = op;
      r.value = val;
      start <= 1'b1;
      req_word <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_for(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (!sb.drained()) @(posedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value(input int span);
      if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, span - 1)];
      return $urandom;
   endfunction

   initial begin
      int blk;
      int k;
      int ins_pct;
      int span;
      bit quiet;
      int item_idx;
      op_type op;

      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'hFFFF_FFFF;
      value_pool[2] = 32'h8000_0000;
      value_pool[3] = 32'h7FFF_FFFF;
      for (k = 4; k < 8; k++) value_pool[k] = $urandom;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty bag: nothing to find
      send_word(OP_ERASE_ALL, 32'd5);
      send_word(OP_ERASE_ONE, 32'd5);
      send_word(OP_COUNT, 32'd5);
      send_word(OP_INSERT, 32'h8000_0000);
      send_word(OP_INSERT, 32'h7FFF_FFFF);
      send_word(OP_INSERT, 32'h0000_0000);
      send_word(OP_INSERT, 32'hFFFF_FFFF);
      send_word(OP_INSERT, 32'h8000_0000);
      send_word(OP_INSERT, 32'h7FFF_FFFF);
      send_word(OP_INSERT, 32'h8000_0000);
      send_word(OP_COUNT, 32'h8000_0000);
      send_word(OP_ERASE_ONE, 32'h7FFF_FFFF);
      send_word(OP_ERASE_ONE, 32'd12345);
      send_word(OP_ERASE_ALL, 32'h8000_0000);
      send_word(OP_COUNT, 32'h0000_0000);
      send_word(OP_ERASE_ALL, 32'hFFFF_FFFF);
      send_word(OP_COUNT, 32'h7FFF_FFFF);
      send_word(OP_ERASE_ONE, 32'h0000_0000);
      send_word(OP_ERASE_ALL, 32'h7FFF_FFFF);
      send_word(OP_COUNT, 32'h7FFF_FFFF);
      wait_drained();

      item_idx = 0;
      for (blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
         ins_pct = (blk == 1 || blk == 10) ? 95 : $urandom_range(5, 95);
         span = $urandom_range(1, 8);
         quiet = ($urandom_range(0, 3) == 0);
         for (k = 0; k < BLOCK_ITEMS; k++) begin
            if ($urandom_range(0, 99) < ins_pct) op = OP_INSERT;
            else op = op_type'($urandom_range(1, 3));
            send_word(op, pick_value(span));
            item_idx++;
            if (!quiet && item_idx < RANDOM_ITEMS - QUIET_TAIL &&
                $urandom_range(0, 3) == 0)
               idle_for($urandom_range(1, 3));
         end
         if (blk % 5 == 4) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.drained())
         $display("[multiset_bag_table] OK");
      else
         $display("[multiset_bag_table] ERROR");
      $finish;
   end

endmodule
